// ----- sv/hhs_pkg.sv -----
// Shared types and codes for the HIP handshake state machine.
package hhs_pkg;

    localparam int unsigned CreditW      = 19;
    localparam int unsigned FactorW      = 11;
    localparam int unsigned FracW        = 10;
    localparam int unsigned BytesW       = 16;
    localparam int unsigned SpiW         = 32;
    localparam int unsigned CountW       = 32;
    localparam int unsigned LocW         = 4;
    localparam int unsigned CfgIdxW      = 2;
    localparam int unsigned CfgDataW     = 32;
    localparam int unsigned InDataW      = 56;
    localparam int unsigned OutDataW     = 96;

    localparam logic [CreditW-1:0] CREDIT_LIMIT_RST = CreditW'(500000);
    localparam logic [FactorW-1:0] AGING_FACTOR_RST = FactorW'(845);
    localparam logic [LocW-1:0]    MIN_UPD_LOCS     = LocW'(2);

    typedef enum logic [3:0] {
        MODE_SEND     = 4'd0,
        MODE_REGISTER = 4'd1,
        MODE_I1       = 4'd2,
        MODE_I2       = 4'd3,
        MODE_R1       = 4'd4,
        MODE_R2       = 4'd5,
        MODE_ESP      = 4'd6,
        MODE_UPDATE   = 4'd7,
        MODE_ADDR_CHG = 4'd8,
        MODE_AGING    = 4'd9
    } mode_t;

    typedef enum logic [3:0] {
        ACT_DROP    = 4'd0,
        ACT_I1      = 4'd1,
        ACT_R1      = 4'd2,
        ACT_I2      = 4'd3,
        ACT_R2      = 4'd4,
        ACT_UPD1    = 4'd5,
        ACT_UPD2    = 4'd6,
        ACT_UPD3    = 4'd7,
        ACT_DELIVER = 4'd8,
        ACT_ESP_OUT = 4'd9,
        ACT_NONE    = 4'd10
    } action_t;

    typedef enum logic [2:0] {
        ST_UNASSOC = 3'd0,
        ST_I1_SENT = 3'd1,
        ST_I2_SENT = 3'd2,
        ST_R2_SENT = 3'd3,
        ST_ESTAB   = 3'd4
    } assoc_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_RVS          = 2'd0,
        CFG_LOCAL_SPI    = 2'd1,
        CFG_CREDIT_LIMIT = 2'd2,
        CFG_AGING        = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic               is_rvs;
        logic [SpiW-1:0]    local_spi;
        logic [CreditW-1:0] credit_limit;
        logic [FactorW-1:0] aging_factor;
    } cfg_t;

    typedef struct packed {
        logic [3:0]        mode;
        logic [SpiW-1:0]   peer_spi;
        logic              came_via_rvs;
        logic [BytesW-1:0] payload_bytes;
        logic [LocW-1:0]   locator_count;
    } item_t;

    typedef struct packed {
        assoc_t             assoc;
        logic [SpiW-1:0]    partner_index;
        logic               via_rvs;
        logic               registering;
        logic               updating;
        logic               addr_validated;
        logic [CountW-1:0]  validated_updates;
        logic [CreditW-1:0] byte_credit;
        logic               trigger_pending;
    } assoc_state_t;

    typedef struct packed {
        action_t            action;
        assoc_t             state_after;
        logic [SpiW-1:0]    partner_spi;
        logic               via_rvs;
        logic               registration;
        logic               release_trigger;
        logic [CreditW-1:0] credit_now;
        logic [CountW-1:0]  update_count;
    } result_t;

endpackage

// ----- sv/hhs_step.sv -----
// Next-state and result logic for one event of the HIP handshake.
module hhs_step (
    input  hhs_pkg::cfg_t         cfg,
    input  hhs_pkg::assoc_state_t cur,
    input  hhs_pkg::item_t        item,
    output hhs_pkg::assoc_state_t nxt,
    output hhs_pkg::result_t      res
);
    import hhs_pkg::*;

    logic [CreditW:0]                credit_sum;
    logic [CreditW+FactorW-1:0]      aged_prod;
    logic [CreditW+FactorW-FracW-1:0] aged;
    logic                            reg_now;

    assign credit_sum = {1'b0, cur.byte_credit} + (CreditW+1)'(item.payload_bytes);
    assign aged_prod  = (CreditW+FactorW)'(cur.byte_credit)
                      * (CreditW+FactorW)'(cfg.aging_factor);
    assign aged       = aged_prod[CreditW+FactorW-1:FracW];
    assign reg_now    = cur.registering | cfg.is_rvs;

    always_comb
    begin
        nxt                 = cur;
        res.action          = ACT_DROP;
        res.via_rvs         = 1'b0;
        res.registration    = 1'b0;
        res.release_trigger = 1'b0;

        case (item.mode)
            MODE_SEND, MODE_REGISTER:
            begin
                if (cur.assoc == ST_UNASSOC)
                begin
                    if (item.mode == MODE_REGISTER)
                    begin
                        nxt.registering = 1'b1;
                    end
                    else
                    begin
                        nxt.registering     = 1'b0;
                        nxt.trigger_pending = 1'b1;
                    end
                    nxt.assoc  = ST_I1_SENT;
                    res.action = ACT_I1;
                end
                else if (cur.assoc == ST_ESTAB)
                begin
                    res.action = ACT_ESP_OUT;
                end
            end
            MODE_I1:
            begin
                if (cur.assoc == ST_UNASSOC)
                begin
                    nxt.partner_index = item.peer_spi;
                    nxt.via_rvs       = cur.via_rvs | item.came_via_rvs;
                    res.action        = ACT_R1;
                    res.via_rvs       = cur.via_rvs | item.came_via_rvs;
                    res.registration  = reg_now;
                end
            end
            MODE_I2:
            begin
                if (cur.assoc == ST_UNASSOC)
                begin
                    res.action       = ACT_R2;
                    res.registration = reg_now;
                    nxt.assoc        = cfg.is_rvs ? ST_ESTAB : ST_R2_SENT;
                end
            end
            MODE_R1:
            begin
                if (cur.assoc == ST_I1_SENT)
                begin
                    nxt.via_rvs       = cur.via_rvs | item.came_via_rvs;
                    nxt.partner_index = item.peer_spi;
                    res.action        = ACT_I2;
                    res.registration  = reg_now;
                    nxt.assoc         = ST_I2_SENT;
                end
            end
            MODE_R2:
            begin
                if (cur.assoc == ST_I2_SENT)
                begin
                    nxt.assoc  = ST_ESTAB;
                    res.action = ACT_NONE;
                    if (cur.trigger_pending)
                    begin
                        res.release_trigger = 1'b1;
                        res.via_rvs         = cur.via_rvs;
                        nxt.trigger_pending = 1'b0;
                    end
                end
            end
            MODE_ESP:
            begin
                if (cur.assoc == ST_R2_SENT)
                begin
                    nxt.assoc = ST_ESTAB;
                    // credit grows only while below the ceiling, then saturates
                    if (cur.byte_credit < cfg.credit_limit)
                    begin
                        if (credit_sum > (CreditW+1)'(cfg.credit_limit))
                        begin
                            nxt.byte_credit = cfg.credit_limit;
                        end
                        else
                        begin
                            nxt.byte_credit = credit_sum[CreditW-1:0];
                        end
                    end
                    res.action = ACT_DELIVER;
                end
                else if (cur.assoc == ST_ESTAB)
                begin
                    res.action = ACT_DELIVER;
                end
            end
            MODE_UPDATE:
            begin
                if (cur.assoc == ST_ESTAB)
                begin
                    if (cur.updating)
                    begin
                        nxt.updating = 1'b0;
                        res.action   = ACT_UPD3;
                    end
                    else if (!cur.addr_validated)
                    begin
                        nxt.addr_validated    = 1'b1;
                        nxt.validated_updates = cur.validated_updates + CountW'(1);
                        res.action            = ACT_NONE;
                    end
                    else if (item.locator_count > MIN_UPD_LOCS)
                    begin
                        nxt.addr_validated = 1'b0;
                        res.action         = ACT_UPD2;
                    end
                end
            end
            MODE_ADDR_CHG:
            begin
                res.action = ACT_NONE;
                if (cur.assoc == ST_ESTAB)
                begin
                    nxt.updating = 1'b1;
                    res.action   = ACT_UPD1;
                end
            end
            MODE_AGING:
            begin
                res.action = ACT_NONE;
                if (aged > (CreditW+FactorW-FracW)'(cfg.credit_limit))
                begin
                    nxt.byte_credit = cfg.credit_limit;
                end
                else
                begin
                    nxt.byte_credit = aged[CreditW-1:0];
                end
            end
            default:
            begin
                res.action = ACT_NONE;
            end
        endcase

        res.state_after  = nxt.assoc;
        res.partner_spi  = nxt.partner_index;
        res.credit_now   = nxt.byte_credit;
        res.update_count = nxt.validated_updates;
    end

endmodule

// ----- sv/hip_handshake_fsm.sv -----
// Top level of the HIP base-exchange and update state machine.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | s_tvalid / s_tready       | s_tuser = mode, s_tdata = event fields
//  output   | m_tvalid / m_tready       | m_tuser = action, m_tdata = result fields
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data (cfg_ready always high)
//
// One word per cycle while m_tready is high. A word waits in the input
// register; the step logic (state update plus one 19x11 credit multiply) then
// writes the association state and the result register at the same edge, so
// the next word always sees the state left by the one before it. Reset clears
// the handshake valids, the association state and the configuration to their
// defaults. When the output stalls, the input register holds one more word
// and then s_tready drops.
module hip_handshake_fsm (
    input  logic                         clk,
    input  logic                         rst_n,
    // input events
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [3:0]                   s_tuser,  // [3:0] mode
    // [31:0] peer_spi, [32] came_via_rendezvous, [48:33] payload_bytes,
    // [52:49] locator_count, [55:53] zero
    input  logic [hhs_pkg::InDataW-1:0]  s_tdata,
    // results
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [3:0]                   m_tuser,  // [3:0] action
    // [2:0] state_after, [34:3] partner_spi_out, [35] via_rendezvous_out,
    // [36] registration_flag, [37] release_trigger, [56:38] credit_now,
    // [88:57] update_count, [95:89] zero
    output logic [hhs_pkg::OutDataW-1:0] m_tdata,
    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hhs_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [hhs_pkg::CfgDataW-1:0] cfg_data
);
    import hhs_pkg::*;

    cfg_t         cfg_reg;
    assoc_state_t state_reg;
    assoc_state_t state_next;
    item_t        item_reg;
    item_t        item_in;
    result_t      res_reg;
    result_t      res_next;
    logic         in_valid_reg;
    logic         out_valid_reg;
    logic         advance;
    logic         in_take;

    // unpack the input word
    assign item_in.mode          = s_tuser;
    assign item_in.peer_spi      = s_tdata[31:0];
    assign item_in.came_via_rvs  = s_tdata[32];
    assign item_in.payload_bytes = s_tdata[48:33];
    assign item_in.locator_count = s_tdata[52:49];

    // advance a word into the result register whenever that slot is free or drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    hhs_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // control state, configuration and association state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg                <= 1'b0;
            out_valid_reg               <= 1'b0;
            cfg_reg.is_rvs              <= 1'b0;
            cfg_reg.local_spi           <= '0;
            cfg_reg.credit_limit        <= CREDIT_LIMIT_RST;
            cfg_reg.aging_factor        <= AGING_FACTOR_RST;
            state_reg.assoc             <= ST_UNASSOC;
            state_reg.partner_index     <= '1;
            state_reg.via_rvs           <= 1'b0;
            state_reg.registering       <= 1'b0;
            state_reg.updating          <= 1'b0;
            state_reg.addr_validated    <= 1'b1;
            state_reg.validated_updates <= '0;
            state_reg.byte_credit       <= '0;
            state_reg.trigger_pending   <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RVS:          cfg_reg.is_rvs       <= cfg_data[0];
                    CFG_LOCAL_SPI:    cfg_reg.local_spi    <= cfg_data[SpiW-1:0];
                    CFG_CREDIT_LIMIT: cfg_reg.credit_limit <= cfg_data[CreditW-1:0];
                    CFG_AGING:        cfg_reg.aging_factor <= cfg_data[FactorW-1:0];
                    default:          cfg_reg.is_rvs       <= cfg_reg.is_rvs;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= item_in;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // pack the result word
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.action;
    assign m_tdata  = {7'd0,
                       res_reg.update_count,
                       res_reg.credit_now,
                       res_reg.release_trigger,
                       res_reg.registration,
                       res_reg.via_rvs,
                       res_reg.partner_spi,
                       res_reg.state_after};

endmodule

// ----- sv/hhs_checker.sv -----
// Port-level checks for the HIP handshake state machine, bound to the top level.
module hhs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [3:0]                   s_tuser,
    input logic [hhs_pkg::InDataW-1:0]  s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [3:0]                   m_tuser,
    input logic [hhs_pkg::OutDataW-1:0] m_tdata,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [hhs_pkg::CfgIdxW-1:0]  cfg_index,
    input logic [hhs_pkg::CfgDataW-1:0] cfg_data
);
    import hhs_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed or dropped");

    // input back-pressure only comes from a stalled output
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output free");

    // a trigger release happens only on R2, landing in established
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[37] |->
            m_tuser == ACT_NONE && m_tdata[2:0] == ST_ESTAB)
        else $error("trigger release outside R2 completion");

    // registration marks only ride on sent R1, I2 or R2
    a_reg_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[36] |->
            m_tuser == ACT_R1 || m_tuser == ACT_I2 || m_tuser == ACT_R2)
        else $error("registration flag on wrong action");

    // an accepted word reaches the output when the receiver does not stall it
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && m_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted word did not reach output");

endmodule

bind hip_handshake_fsm hhs_checker u_hhs_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for hip_handshake_fsm: table-driven handshake walk, then random events.
`timescale 1ns / 100ps

module tb;

    import hhs_pkg::*;

    // Modes past the last defined event; the block must answer them with "none".
    localparam logic [3:0] MODE_SPARE_LO = 4'd10;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    localparam int unsigned PHASES       = 5;
    localparam int unsigned PHASE_WORDS  = 340;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE       = 4;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned REPORT_MAX   = 10;

    // Which side of the base exchange the single reset-to-established walk takes.
    typedef enum logic [1:0] {
        ROUTE_BOTH,
        ROUTE_INITIATOR,
        ROUTE_RESPONDER
    } route_t;

    typedef struct {
        route_t  route;
        item_t   ev;
        logic    fixed;     // expectation typed into the table
        result_t fixed_res;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [3:0]            s_tuser;
    logic [InDataW-1:0]    s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [3:0]            m_tuser;
    logic [OutDataW-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CfgIdxW-1:0]    cfg_index;
    logic [CfgDataW-1:0]   cfg_data;

    // Shadow configuration.
    logic               rvs_node;
    logic [SpiW-1:0]    own_spi;
    logic [CreditW-1:0] credit_cap;
    logic [FactorW-1:0] age_factor;

    // Shadow association state.
    assoc_t             assoc_now;
    logic [SpiW-1:0]    partner_now;
    logic               via_flag;
    logic               registering;
    logic               updating;
    logic               addr_ok;
    logic [CountW-1:0]  update_total;
    logic [CreditW-1:0] credit;
    logic               trigger_armed;

    result_t due_results[$];
    row_t    plan[$];
    int      faults;
    int      cycle_count;
    logic    calm;       // no idling on either side
    logic    hold_req;   // receiver holds off for a long stretch

    hip_handshake_fsm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the shadow association by one event and return the word it must produce.
    function automatic result_t exchange_step(input item_t ev);
        result_t            r;
        logic               reg_view;
        logic [CreditW:0]   sum;
        logic [29:0]        prod;
        logic [CreditW:0]   aged;
        r = '0;
        r.action = ACT_DROP;
        reg_view = registering | rvs_node;
        case (ev.mode)
            MODE_SEND, MODE_REGISTER:
            begin
                if (assoc_now == ST_UNASSOC)
                begin
                    // A plain send arms the trigger; a registration request does not.
                    if (ev.mode == MODE_REGISTER)
                        registering = 1'b1;
                    else
                    begin
                        registering = 1'b0;
                        trigger_armed = 1'b1;
                    end
                    assoc_now = ST_I1_SENT;
                    r.action = ACT_I1;
                end
                else if (assoc_now == ST_ESTAB)
                    r.action = ACT_ESP_OUT;
            end
            MODE_I1:
            begin
                // I1 answers with R1 but leaves the node unassociated; via is sticky.
                if (assoc_now == ST_UNASSOC)
                begin
                    partner_now = ev.peer_spi;
                    if (ev.came_via_rvs)
                        via_flag = 1'b1;
                    r.action = ACT_R1;
                    r.via_rvs = via_flag;
                    r.registration = reg_view;
                end
            end
            MODE_I2:
            begin
                if (assoc_now == ST_UNASSOC)
                begin
                    r.action = ACT_R2;
                    r.registration = reg_view;
                    assoc_now = rvs_node ? ST_ESTAB : ST_R2_SENT;
                end
            end
            MODE_R1:
            begin
                if (assoc_now == ST_I1_SENT)
                begin
                    if (ev.came_via_rvs)
                        via_flag = 1'b1;
                    partner_now = ev.peer_spi;
                    r.action = ACT_I2;
                    r.registration = reg_view;
                    assoc_now = ST_I2_SENT;
                end
            end
            MODE_R2:
            begin
                if (assoc_now == ST_I2_SENT)
                begin
                    assoc_now = ST_ESTAB;
                    r.action = ACT_NONE;
                    if (trigger_armed)
                    begin
                        r.release_trigger = 1'b1;
                        r.via_rvs = via_flag;
                        trigger_armed = 1'b0;
                    end
                end
            end
            MODE_ESP:
            begin
                // Credit only accrues on the first ESP after R2, and only below the cap.
                if (assoc_now == ST_R2_SENT)
                begin
                    assoc_now = ST_ESTAB;
                    if (credit < credit_cap)
                    begin
                        sum = {1'b0, credit} + (CreditW+1)'(ev.payload_bytes);
                        credit = (sum > {1'b0, credit_cap}) ? credit_cap : sum[CreditW-1:0];
                    end
                    r.action = ACT_DELIVER;
                end
                else if (assoc_now == ST_ESTAB)
                    r.action = ACT_DELIVER;
            end
            MODE_UPDATE:
            begin
                if (assoc_now == ST_ESTAB)
                begin
                    if (!updating)
                    begin
                        if (addr_ok)
                        begin
                            if (ev.locator_count > MIN_UPD_LOCS)
                            begin
                                addr_ok = 1'b0;
                                r.action = ACT_UPD2;
                            end
                        end
                        else
                        begin
                            addr_ok = 1'b1;
                            update_total = update_total + CountW'(1);
                            r.action = ACT_NONE;
                        end
                    end
                    else
                    begin
                        updating = 1'b0;
                        r.action = ACT_UPD3;
                    end
                end
            end
            MODE_ADDR_CHG:
            begin
                r.action = ACT_NONE;
                if (assoc_now == ST_ESTAB)
                begin
                    updating = 1'b1;
                    r.action = ACT_UPD1;
                end
            end
            MODE_AGING:
            begin
                // Q1.10 multiply, truncated, then clamp to the cap.
                prod = 30'(credit) * 30'(age_factor);
                aged = prod[29:FracW];
                credit = (aged > {1'b0, credit_cap}) ? credit_cap : aged[CreditW-1:0];
                r.action = ACT_NONE;
            end
            default:
                r.action = ACT_NONE;
        endcase
        r.state_after = assoc_now;
        r.partner_spi = partner_now;
        r.credit_now = credit;
        r.update_count = update_total;
        return r;
    endfunction

    // Word produced by an event that finds the block still fresh out of reset.
    function automatic result_t at_rest(input action_t a);
        result_t r;
        r = '0;
        r.action = a;
        r.state_after = ST_UNASSOC;
        r.partner_spi = '1;
        return r;
    endfunction

    function automatic void plan_row(input route_t rt, input logic [3:0] m,
                                     input logic [SpiW-1:0] spi, input logic via,
                                     input logic [BytesW-1:0] bytes,
                                     input logic [LocW-1:0] locs,
                                     input logic fixed, input result_t fixed_res);
        row_t row;
        row.route = rt;
        row.ev.mode = m;
        row.ev.peer_spi = spi;
        row.ev.came_via_rvs = via;
        row.ev.payload_bytes = bytes;
        row.ev.locator_count = locs;
        row.fixed = fixed;
        row.fixed_res = fixed_res;
        plan.insert(plan.size(), row);
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("act=%0d st=%0d spi=%h via=%b reg=%b rel=%b credit=%0d count=%0d",
                         r.action, r.state_after, r.partner_spi, r.via_rvs, r.registration,
                         r.release_trigger, r.credit_now, r.update_count);
    endfunction

    // Offer one word after a random gap, hold it until taken, then log what it must produce.
    task automatic push_event(input item_t ev, input logic fixed, input result_t fixed_res);
        int      gap;
        result_t want;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.mode;
        s_tdata  <= {3'b000, ev.locator_count, ev.payload_bytes, ev.came_via_rvs, ev.peer_spi};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = exchange_step(ev);
        if (fixed)
            want = fixed_res;
        due_results.insert(due_results.size(), want);
    endtask

    // Drop the input valid and wait until every expected word has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_RVS:          rvs_node = val[0];
            CFG_LOCAL_SPI:    own_spi = val;
            CFG_CREDIT_LIMIT: credit_cap = val[CreditW-1:0];
            CFG_AGING:        age_factor = val[FactorW-1:0];
            default:          ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stall per word, with an occasional long hold-off on request.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Compare each accepted word with the oldest expectation, field by field.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '0;
            got.action          = action_t'(m_tuser);
            got.state_after     = assoc_t'(m_tdata[2:0]);
            got.partner_spi     = m_tdata[34:3];
            got.via_rvs         = m_tdata[35];
            got.registration    = m_tdata[36];
            got.release_trigger = m_tdata[37];
            got.credit_now      = m_tdata[56:38];
            got.update_count    = m_tdata[88:57];
            if (due_results.size() == 0)
            begin
                if (faults < REPORT_MAX)
                    $display("unexpected word: %s", show(got));
                faults = faults + 1;
            end
            else
            begin
                want = due_results.pop_front();
                if (got.action !== want.action || got.state_after !== want.state_after ||
                    got.partner_spi !== want.partner_spi || got.via_rvs !== want.via_rvs ||
                    got.registration !== want.registration ||
                    got.release_trigger !== want.release_trigger ||
                    got.credit_now !== want.credit_now ||
                    got.update_count !== want.update_count)
                begin
                    if (faults < REPORT_MAX)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                    faults = faults + 1;
                end
            end
        end
    end

    // Watchdog: ends a hung run.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        route_t     route_pick;
        logic [3:0] entry_mode;
        logic [3:0] other_mode;
        item_t      ev;
        int         r;
        // Drive every input known from time zero and hold reset.
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = '0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_RVS;
        cfg_data    = '0;
        faults      = 0;
        cycle_count = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;

        rvs_node      = 1'b0;
        own_spi       = '0;
        credit_cap    = CREDIT_LIMIT_RST;
        age_factor    = AGING_FACTOR_RST;
        assoc_now     = ST_UNASSOC;
        partner_now   = '1;
        via_flag      = 1'b0;
        registering   = 1'b0;
        updating      = 1'b0;
        addr_ok       = 1'b1;
        update_total  = '0;
        credit        = '0;
        trigger_armed = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The association never leaves established, so one run walks one side of the
        // exchange; the seed picks which, and whether the initiator also registers.
        route_pick = $urandom_range(0, 1) ? ROUTE_INITIATOR : ROUTE_RESPONDER;
        entry_mode = $urandom_range(0, 1) ? MODE_SEND : MODE_REGISTER;
        other_mode = (entry_mode == MODE_SEND) ? MODE_REGISTER : MODE_SEND;

        if (route_pick == ROUTE_INITIATOR)
        begin
            write_reg(CFG_RVS, CfgDataW'($urandom_range(0, 1)));
            write_reg(CFG_LOCAL_SPI, $urandom);
            write_reg(CFG_CREDIT_LIMIT, CfgDataW'(CREDIT_LIMIT_RST));
        end
        else
        begin
            // Responder must not be a rendezvous server, or I2 skips the credit state.
            write_reg(CFG_RVS, '0);
            write_reg(CFG_LOCAL_SPI, $urandom);
            write_reg(CFG_CREDIT_LIMIT,
                      $urandom_range(0, 1) ? CfgDataW'(40000) : CfgDataW'(CREDIT_LIMIT_RST));
        end
        write_reg(CFG_AGING, CfgDataW'(AGING_FACTOR_RST));

        // Fresh out of reset: every received packet but I1 and I2 is dropped,
        // spare modes, aging and address changes do nothing.
        plan_row(ROUTE_BOTH, MODE_ESP, '0, 1'b0, 16'hFFFF, '0, 1'b1, at_rest(ACT_DROP));
        plan_row(ROUTE_BOTH, MODE_SPARE_HI, '1, 1'b1, 16'hFFFF, 4'hF, 1'b1, at_rest(ACT_NONE));
        plan_row(ROUTE_BOTH, MODE_SPARE_LO, '0, 1'b0, '0, '0, 1'b1, at_rest(ACT_NONE));
        plan_row(ROUTE_BOTH, MODE_AGING, '0, 1'b0, '0, '0, 1'b1, at_rest(ACT_NONE));
        plan_row(ROUTE_BOTH, MODE_ADDR_CHG, '0, 1'b0, '0, '0, 1'b1, at_rest(ACT_NONE));
        plan_row(ROUTE_BOTH, MODE_UPDATE, '0, 1'b0, '0, 4'hF, 1'b1, at_rest(ACT_DROP));
        plan_row(ROUTE_BOTH, MODE_R1, 32'h1234_5678, 1'b1, '0, '0, 1'b1, at_rest(ACT_DROP));
        plan_row(ROUTE_BOTH, MODE_R2, '0, 1'b0, '0, '0, 1'b1, at_rest(ACT_DROP));
        // I1 answers with R1 and stays unassociated; the via mark, once set, sticks.
        plan_row(ROUTE_BOTH, MODE_I1, '0, 1'b0, '0, '0, 1'b0, '0);
        plan_row(ROUTE_BOTH, MODE_I1, '1, 1'b1, '0, '0, 1'b0, '0);
        plan_row(ROUTE_BOTH, MODE_I1, 32'hA5A5_5A5A, 1'b0, '0, '0, 1'b0, '0);
        // Initiator: I1 out, stray local request and I2 dropped, R1 -> I2, early ESP dropped, R2 -> done.
        plan_row(ROUTE_INITIATOR, entry_mode, '0, 1'b0, '0, '0, 1'b0, '0);
        plan_row(ROUTE_INITIATOR, other_mode, '0, 1'b0, '0, '0, 1'b0, '0);
        plan_row(ROUTE_INITIATOR, MODE_I2, '0, 1'b0, '0, '0, 1'b0, '0);
        plan_row(ROUTE_INITIATOR, MODE_R1, 32'h0BAD_F00D, 1'b0, '0, '0, 1'b0, '0);
        plan_row(ROUTE_INITIATOR, MODE_ESP, '0, 1'b0, 16'h00FF, '0, 1'b0, '0);
        plan_row(ROUTE_INITIATOR, MODE_R2, '0, 1'b0, '0, '0, 1'b0, '0);
        // Responder: I2 -> R2, anything but ESP dropped, first ESP books credit.
        plan_row(ROUTE_RESPONDER, MODE_I2, '0, 1'b0, '0, '0, 1'b0, '0);
        plan_row(ROUTE_RESPONDER, MODE_SEND, '0, 1'b0, '0, '0, 1'b0, '0);
        plan_row(ROUTE_RESPONDER, MODE_R2, '0, 1'b0, '0, '0, 1'b0, '0);
        plan_row(ROUTE_RESPONDER, MODE_ESP, '0, 1'b0, 16'hFFFF, '0, 1'b0, '0);
        // Established: local traffic, ESP, a full update exchange, one aging tick.
        plan_row(ROUTE_BOTH, MODE_REGISTER, '0, 1'b0, '0, '0, 1'b0, '0);
        plan_row(ROUTE_BOTH, MODE_ESP, '0, 1'b0, '0, '0, 1'b0, '0);
        plan_row(ROUTE_BOTH, MODE_UPDATE, '0, 1'b0, '0, 4'd2, 1'b0, '0);
        plan_row(ROUTE_BOTH, MODE_UPDATE, '0, 1'b0, '0, 4'd3, 1'b0, '0);
        plan_row(ROUTE_BOTH, MODE_UPDATE, '0, 1'b0, '0, 4'd0, 1'b0, '0);
        plan_row(ROUTE_BOTH, MODE_ADDR_CHG, '0, 1'b0, '0, '0, 1'b0, '0);
        plan_row(ROUTE_BOTH, MODE_UPDATE, '0, 1'b0, '0, 4'hF, 1'b0, '0);
        plan_row(ROUTE_BOTH, MODE_AGING, '0, 1'b0, '0, '0, 1'b0, '0);

        foreach (plan[i])
        begin
            if (plan[i].route == ROUTE_BOTH || plan[i].route == route_pick)
                push_event(plan[i].ev, plan[i].fixed, plan[i].fixed_res);
        end

        // Random phases, each under its own configuration, written while idle.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            repeat (SETTLE) @(posedge clk);
            case (ph)
                0:
                begin
                    write_reg(CFG_RVS, CfgDataW'($urandom_range(0, 1)));
                    write_reg(CFG_LOCAL_SPI, '1);
                    write_reg(CFG_CREDIT_LIMIT, CfgDataW'(524287));
                    write_reg(CFG_AGING, CfgDataW'(1024));
                end
                1:
                begin
                    // Factor above one: credit grows until it pins at the cap.
                    write_reg(CFG_RVS, '0);
                    write_reg(CFG_LOCAL_SPI, '0);
                    write_reg(CFG_AGING, CfgDataW'(2047));
                end
                2:
                begin
                    write_reg(CFG_CREDIT_LIMIT, CfgDataW'($urandom_range(0, 524287)));
                    write_reg(CFG_AGING, CfgDataW'(AGING_FACTOR_RST));
                end
                3:
                begin
                    write_reg(CFG_RVS, '1);
                    write_reg(CFG_LOCAL_SPI, $urandom);
                    write_reg(CFG_AGING, CfgDataW'($urandom_range(0, 1024)));
                end
                default:
                begin
                    write_reg(CFG_CREDIT_LIMIT, '0);
                    write_reg(CFG_AGING, '0);
                end
            endcase
            calm = (ph == 1 || ph == 4);
            // Stall the output long enough to back the block up into its input.
            if (ph == 2)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (ph == 3 && n == PHASE_WORDS / 2)
                    wait_drained();
                r = $urandom_range(0, 99);
                ev.peer_spi = $urandom;
                ev.came_via_rvs = 1'($urandom_range(0, 1));
                ev.payload_bytes = BytesW'($urandom_range(0, 65535));
                ev.locator_count = LocW'($urandom_range(0, 15));
                // Weight toward the update exchange, which holds most of the state.
                if (r < 30)
                    ev.mode = MODE_UPDATE;
                else if (r < 45)
                    ev.mode = MODE_ADDR_CHG;
                else if (r < 60)
                    ev.mode = MODE_ESP;
                else if (r < 70)
                    ev.mode = MODE_AGING;
                else if (r < 78)
                    ev.mode = $urandom_range(0, 1) ? MODE_SEND : MODE_REGISTER;
                else if (r < 92)
                    ev.mode = 4'($urandom_range(MODE_I1, MODE_R2));
                else
                    ev.mode = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
                push_event(ev, 1'b0, '0);
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (faults == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
